>>> hw/rtl/limit_order_matcher_defines.svh
// assertion macros for the limit order matcher checker
`ifndef LIMIT_ORDER_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_MATCHER_DEFINES_SVH

// same-cycle implication
`define LOM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lom_pkg.sv
// shared types, constants and helpers for the limit order matcher
package lom_pkg;

    localparam int DEFAULT_BOOK_DEPTH = 32;

    typedef enum logic [1:0] {
        KIND_TRADE  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_ZERO   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] amount;
        logic [15:0] owner;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic  capture;
        logic  insert;
        logic  scan_start;
        logic  scan_read;
        logic  trade;
        logic  fetch_last;
        logic  remove;
        logic  load_status;
        kind_t status_kind;
    } lom_cmd_t;

    typedef struct packed {
        logic amount_zero;
        logic side_full;
        logic book_empty;
        logic scan_last;
        logic crossed;
    } lom_status_t;

    // true when stamp a arrived before stamp b, wrap aware
    function automatic logic older(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

>>> hw/rtl/limit_order_matcher.sv
// a zero-quantity or full-side reject is decided in S_CHECK, the state after acceptance, and registered to the output
// each match round scans max(bid_count, ask_count) entries through one read port per side,
// then passes S_DRAIN and S_DECIDE, and S_FETCH and S_REMOVE as well when it trades
// one order is in work at a time; the next is taken once its final status is delivered
// reset clears entry counts, arrival counter and control; book memories are not cleared
// top level of the limit order matcher
module limit_order_matcher
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // trader, limit_price, amount
    input  logic [0:0]  s_axis_tuser,   // side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // buyer, seller, fill_amount, fill_price
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    lom_cmd_t    cmd;
    lom_status_t status;

    lom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    lom_datapath #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_side  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_kind (m_axis_tuser),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule

>>> hw/rtl/lom_ctrl.sv
// control state machine of the limit order matcher
module lom_ctrl
    import lom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output lom_cmd_t    cmd,
    input  lom_status_t status
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_MSTART = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_DECIDE = 8'b0010_0000,
        S_FETCH  = 8'b0100_0000,
        S_REMOVE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_kind = KIND_ACCEPT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.amount_zero)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_kind = KIND_ZERO;
                    state_next      = S_IDLE;
                end
                else if (status.side_full)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_kind = KIND_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                if (status.book_empty)
                begin
                    if (slot_free)
                    begin
                        cmd.load_status = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    if (status.crossed)
                    begin
                        cmd.trade  = 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        cmd.load_status = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch_last = 1'b1;
                state_next     = S_REMOVE;
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_MSTART;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || cmd.load_status || cmd.trade;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/lom_datapath.sv
// book memories, best-of-book scan and output register of the limit order matcher
module lom_datapath
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lom_cmd_t    cmd,
    output lom_status_t status,
    input  logic [0:0]  in_side,
    input  logic [79:0] in_data,
    output logic [1:0]  out_kind,
    output logic [95:0] out_data,
    output logic        out_last
);

    localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BOOK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    entry_t bid_mem [BOOK_DEPTH];
    entry_t ask_mem [BOOK_DEPTH];

    logic             side_reg;
    logic [15:0]      trader_reg;
    logic [31:0]      price_reg;
    logic [31:0]      amount_reg;
    logic [CNT_W-1:0] bid_count_reg, bid_count_next;
    logic [CNT_W-1:0] ask_count_reg, ask_count_next;
    logic [31:0]      arrival_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] tag_reg;
    entry_t           bid_rd_reg, ask_rd_reg;
    entry_t           bid_best_reg, ask_best_reg;
    logic [IDX_W-1:0] bid_best_idx_reg, ask_best_idx_reg;
    logic [1:0]       out_kind_reg;
    logic [95:0]      out_data_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] scan_len, bid_last, ask_last;
    logic [IDX_W-1:0] bid_rd_addr, ask_rd_addr;
    logic             bid_we, ask_we;
    logic [IDX_W-1:0] bid_wa, ask_wa;
    entry_t           bid_wd, ask_wd;
    logic             bid_take, ask_take;
    logic [31:0]      fill_q;
    logic             bid_gone, ask_gone;

    assign scan_len = (bid_count_reg > ask_count_reg) ? bid_count_reg : ask_count_reg;
    assign bid_last = bid_count_reg - ONE_CNT;
    assign ask_last = ask_count_reg - ONE_CNT;
    assign fill_q   = (bid_best_reg.amount < ask_best_reg.amount) ? bid_best_reg.amount
                                                                  : ask_best_reg.amount;
    assign bid_gone = (bid_best_reg.amount == 32'd0);
    assign ask_gone = (ask_best_reg.amount == 32'd0);

    assign status.amount_zero = (amount_reg == 32'd0);
    assign status.side_full   = side_reg ? (ask_count_reg == DEPTH_CNT)
                                         : (bid_count_reg == DEPTH_CNT);
    assign status.book_empty  = (bid_count_reg == '0) || (ask_count_reg == '0);
    assign status.scan_last   = (scan_idx_reg == scan_len - ONE_CNT);
    assign status.crossed     = (bid_best_reg.price >= ask_best_reg.price);

    assign bid_rd_addr = cmd.fetch_last ? bid_last[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];
    assign ask_rd_addr = cmd.fetch_last ? ask_last[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    // best-of-book compare on each returned scan word
    assign bid_take = pend_reg && (CNT_W'(tag_reg) < bid_count_reg) &&
                      ((tag_reg == '0) || (bid_rd_reg.price > bid_best_reg.price) ||
                       ((bid_rd_reg.price == bid_best_reg.price) &&
                        older(bid_rd_reg.stamp, bid_best_reg.stamp)));
    assign ask_take = pend_reg && (CNT_W'(tag_reg) < ask_count_reg) &&
                      ((tag_reg == '0) || (ask_rd_reg.price < ask_best_reg.price) ||
                       ((ask_rd_reg.price == ask_best_reg.price) &&
                        older(ask_rd_reg.stamp, ask_best_reg.stamp)));

    always_comb
    begin
        bid_we = 1'b0;
        bid_wa = bid_best_idx_reg;
        bid_wd = bid_rd_reg;
        ask_we = 1'b0;
        ask_wa = ask_best_idx_reg;
        ask_wd = ask_rd_reg;
        if (cmd.insert)
        begin
            if (side_reg)
            begin
                ask_we = 1'b1;
                ask_wa = ask_count_reg[IDX_W-1:0];
                ask_wd = '{price: price_reg, amount: amount_reg, owner: trader_reg,
                           stamp: arrival_reg};
            end
            else
            begin
                bid_we = 1'b1;
                bid_wa = bid_count_reg[IDX_W-1:0];
                bid_wd = '{price: price_reg, amount: amount_reg, owner: trader_reg,
                           stamp: arrival_reg};
            end
        end
        if (cmd.trade)
        begin
            bid_we        = 1'b1;
            bid_wd        = bid_best_reg;
            bid_wd.amount = bid_best_reg.amount - fill_q;
            ask_we        = 1'b1;
            ask_wd        = ask_best_reg;
            ask_wd.amount = ask_best_reg.amount - fill_q;
        end
        if (cmd.remove)
        begin
            bid_we = bid_gone;
            ask_we = ask_gone;
        end
    end

    always_comb
    begin
        bid_count_next = bid_count_reg;
        ask_count_next = ask_count_reg;
        if (cmd.insert)
        begin
            if (side_reg)
            begin
                ask_count_next = ask_count_reg + ONE_CNT;
            end
            else
            begin
                bid_count_next = bid_count_reg + ONE_CNT;
            end
        end
        if (cmd.remove)
        begin
            if (bid_gone)
            begin
                bid_count_next = bid_last;
            end
            if (ask_gone)
            begin
                ask_count_next = ask_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bid_we)
        begin
            bid_mem[bid_wa] <= bid_wd;
        end
        if (ask_we)
        begin
            ask_mem[ask_wa] <= ask_wd;
        end
        bid_rd_reg <= bid_mem[bid_rd_addr];
        ask_rd_reg <= ask_mem[ask_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_count_reg <= '0;
            ask_count_reg <= '0;
            arrival_reg   <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            bid_count_reg <= bid_count_next;
            ask_count_reg <= ask_count_next;
            if (cmd.insert)
            begin
                arrival_reg <= arrival_reg + 32'd1;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_read)
            begin
                scan_idx_reg <= scan_idx_reg + ONE_CNT;
            end
            pend_reg <= cmd.scan_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            side_reg   <= in_side[0];
            trader_reg <= in_data[15:0];
            price_reg  <= in_data[47:16];
            amount_reg <= in_data[79:48];
        end
        tag_reg <= scan_idx_reg[IDX_W-1:0];
        if (bid_take)
        begin
            bid_best_reg     <= bid_rd_reg;
            bid_best_idx_reg <= tag_reg;
        end
        if (ask_take)
        begin
            ask_best_reg     <= ask_rd_reg;
            ask_best_idx_reg <= tag_reg;
        end
        if (cmd.trade)
        begin
            bid_best_reg.amount <= bid_best_reg.amount - fill_q;
            ask_best_reg.amount <= ask_best_reg.amount - fill_q;
            out_kind_reg        <= KIND_TRADE;
            out_data_reg        <= {bid_best_reg.price, fill_q, ask_best_reg.owner,
                                    bid_best_reg.owner};
            out_last_reg        <= 1'b0;
        end
        else if (cmd.load_status)
        begin
            out_kind_reg <= cmd.status_kind;
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign out_kind = out_kind_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

>>> hw/rtl/lom_checker.sv
// port-level assertions for the limit order matcher, bound to the top level
`include "limit_order_matcher_defines.svh"

module lom_checker
    import lom_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `LOM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output transaction changed while stalled")
    `LOM_ASSERT_NOW(a_no_take_busy, m_axis_tvalid, !s_axis_tready, "input taken while output pending")
    `LOM_ASSERT_NOW(a_status_clean, m_axis_tvalid && m_axis_tlast, (m_axis_tdata == 96'd0) && (m_axis_tuser != KIND_TRADE), "status transaction malformed")
    `LOM_ASSERT_NOW(a_trade_kind, m_axis_tvalid && !m_axis_tlast, (m_axis_tuser == KIND_TRADE) && (m_axis_tdata[63:32] != 32'd0), "trade transaction malformed")

endmodule

bind limit_order_matcher lom_checker u_lom_checker (.*);

>>> tb/limit_order_matcher_tb.sv
// self-checking testbench for the limit order matcher: directed table, then random order flow
module limit_order_matcher_tb;
    import lom_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEFAULT_BOOK_DEPTH;
    localparam int RANDOM_ORDERS = 410;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        kind_t       kind;
        logic [15:0] buyer;
        logic [15:0] seller;
        logic [31:0] fill_amount;
        logic [31:0] fill_price;
        logic        last;
    } report_t;

    typedef struct {
        logic        side;
        logic [15:0] trader;
        logic [31:0] price;
        logic [31:0] amount;
        int          repeats;
        logic        fixed;
        kind_t       fixed_kind;
    } order_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // shadow book
    logic [31:0] bid_px [DEPTH];
    logic [31:0] bid_qty [DEPTH];
    logic [15:0] bid_who [DEPTH];
    logic [31:0] bid_seq [DEPTH];
    logic [31:0] ask_px [DEPTH];
    logic [31:0] ask_qty [DEPTH];
    logic [15:0] ask_who [DEPTH];
    logic [31:0] ask_seq [DEPTH];
    int          bid_n = 0;
    int          ask_n = 0;
    logic [31:0] next_seq = '0;

    report_t     pending_reports [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          hold_cnt = 0;
    int          run_left = 0;
    int          stall_left = 0;
    bit          hold_req = 0;
    order_row_t  rows [12];

    limit_order_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic bit arrived_first(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void queue_report(input report_t r);
        pending_reports = {pending_reports, r};
    endfunction

    function automatic report_t status_report(input kind_t k);
        report_t r;
        r.kind = k;
        r.buyer = '0;
        r.seller = '0;
        r.fill_amount = '0;
        r.fill_price = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic match_order(input logic side, input logic [15:0] trader,
                               input logic [31:0] price, input logic [31:0] amount);
        int b;
        int a;
        int trades;
        logic [31:0] q;
        report_t r;
        trades = 0;
        if (amount == 0) begin
            queue_report(status_report(KIND_ZERO));
            return;
        end
        if ((side == 1'b0 && bid_n >= DEPTH) || (side == 1'b1 && ask_n >= DEPTH)) begin
            queue_report(status_report(KIND_FULL));
            return;
        end
        if (side == 1'b0) begin
            bid_px[bid_n] = price;
            bid_qty[bid_n] = amount;
            bid_who[bid_n] = trader;
            bid_seq[bid_n] = next_seq;
            bid_n++;
        end
        else begin
            ask_px[ask_n] = price;
            ask_qty[ask_n] = amount;
            ask_who[ask_n] = trader;
            ask_seq[ask_n] = next_seq;
            ask_n++;
        end
        next_seq++;
        while (bid_n > 0 && ask_n > 0 && trades < 2 * DEPTH) begin
            b = 0;
            a = 0;
            for (int i = 1; i < bid_n; i++)
                if (bid_px[i] > bid_px[b] ||
                    (bid_px[i] == bid_px[b] && arrived_first(bid_seq[i], bid_seq[b])))
                    b = i;
            for (int i = 1; i < ask_n; i++)
                if (ask_px[i] < ask_px[a] ||
                    (ask_px[i] == ask_px[a] && arrived_first(ask_seq[i], ask_seq[a])))
                    a = i;
            if (bid_px[b] < ask_px[a])
                break;
            q = (bid_qty[b] < ask_qty[a]) ? bid_qty[b] : ask_qty[a];
            r.kind = KIND_TRADE;
            r.buyer = bid_who[b];
            r.seller = ask_who[a];
            r.fill_amount = q;
            r.fill_price = bid_px[b];
            r.last = 1'b0;
            queue_report(r);
            trades++;
            bid_qty[b] -= q;
            ask_qty[a] -= q;
            if (bid_qty[b] == 0) begin
                bid_n--;
                bid_px[b] = bid_px[bid_n];
                bid_qty[b] = bid_qty[bid_n];
                bid_who[b] = bid_who[bid_n];
                bid_seq[b] = bid_seq[bid_n];
            end
            if (ask_qty[a] == 0) begin
                ask_n--;
                ask_px[a] = ask_px[ask_n];
                ask_qty[a] = ask_qty[ask_n];
                ask_who[a] = ask_who[ask_n];
                ask_seq[a] = ask_seq[ask_n];
            end
        end
        queue_report(status_report(KIND_ACCEPT));
    endtask

    task automatic place_order(input logic side, input logic [15:0] trader,
                               input logic [31:0] price, input logic [31:0] amount,
                               input logic fixed, input kind_t fixed_kind);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= side;
        s_axis_tdata <= {amount, price, trader};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (fixed)
            queue_report(status_report(fixed_kind));
        else
            match_order(side, trader, price, amount);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // output checker and stall pattern
    always @(posedge clk or negedge rst_n) begin
        report_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected transaction: kind %0d", m_axis_tuser);
                    errors++;
                end
                else begin
                    want = pending_reports.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[15:0] !== want.buyer) begin
                        $error("buyer: expected %0h, got %0h", want.buyer, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[31:16] !== want.seller) begin
                        $error("seller: expected %0h, got %0h", want.seller,
                               m_axis_tdata[31:16]);
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== want.fill_amount) begin
                        $error("fill_amount: expected %0h, got %0h", want.fill_amount,
                               m_axis_tdata[63:32]);
                        errors++;
                    end
                    if (m_axis_tdata[95:64] !== want.fill_price) begin
                        $error("fill_price: expected %0h, got %0h", want.fill_price,
                               m_axis_tdata[95:64]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                run_left = $urandom_range(1, 40);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk) begin
        if (rst_n && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("limit_order_matcher_tb failed");
            $finish;
        end
    end

    initial begin
        logic        side;
        logic [31:0] price;
        logic [31:0] amount;
        rows[0]  = '{1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, KIND_ZERO};
        rows[1]  = '{1'b1, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1'b0, KIND_ACCEPT};
        rows[2]  = '{1'b0, 16'h0000, 32'hffff_ffff, 32'h0000_0001, 1, 1'b0, KIND_ACCEPT};
        rows[3]  = '{1'b0, 16'h1234, 32'd100, 32'd5, DEPTH, 1'b0, KIND_ACCEPT};
        rows[4]  = '{1'b0, 16'h0007, 32'd200, 32'd9, 1, 1'b1, KIND_FULL};
        rows[5]  = '{1'b0, 16'h0007, 32'd200, 32'd0, 1, 1'b1, KIND_ZERO};
        rows[6]  = '{1'b1, 16'haaaa, 32'h0000_0000, 32'hffff_ffff, 1, 1'b0, KIND_ACCEPT};
        rows[7]  = '{1'b0, 16'h5555, 32'h0000_0000, 32'd3, 1, 1'b0, KIND_ACCEPT};
        rows[8]  = '{1'b0, 16'h8001, 32'h0000_0000, 32'hffff_ffff, 1, 1'b0, KIND_ACCEPT};
        rows[9]  = '{1'b1, 16'h0101, 32'd50, 32'd4, 1, 1'b0, KIND_ACCEPT};
        rows[10] = '{1'b1, 16'h0202, 32'd50, 32'd4, 1, 1'b0, KIND_ACCEPT};
        rows[11] = '{1'b0, 16'h0303, 32'd60, 32'd6, 1, 1'b0, KIND_ACCEPT};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            for (int k = 0; k < rows[i].repeats; k++)
                place_order(rows[i].side, rows[i].trader, rows[i].price + k,
                            rows[i].amount, rows[i].fixed, rows[i].fixed_kind);

        for (int n = 0; n < RANDOM_ORDERS; n++) begin
            if (n == 100)
                hold_req = 1;
            if (n == 250)
                wait_drained();
            side = 1'($urandom_range(0, 1));
            price = ($urandom_range(0, 15) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 40);
            case ($urandom_range(0, 29))
                0:       amount = '0;
                1, 2:    amount = $urandom;
                default: amount = $urandom_range(1, 100);
            endcase
            place_order(side, 16'($urandom_range(0, 16'hffff)), price, amount, 1'b0,
                        KIND_ACCEPT);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("limit_order_matcher_tb passed");
        else
            $display("limit_order_matcher_tb failed");
        $finish;
    end

endmodule
